// File: sv/bezier_trajectory_generator_defines.svh
// Assertion macros for the cubic Bezier trajectory generator checker.
// Depends on nothing; the using module provides clk and rst.
`ifndef BEZIER_TRAJECTORY_GENERATOR_DEFINES_SVH
`define BEZIER_TRAJECTORY_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTG_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/btg_pkg.sv
// Shared types and constants of the cubic Bezier trajectory generator.
// Used by every module of the block; depends on nothing.
package btg_pkg;

  localparam int DEF_MAX_STEPS   = 64;
  localparam int DEF_COORD_BITS  = 11;
  localparam int DEF_T_FRAC_BITS = 16;

  localparam int NS_BITS    = 7;
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_SHIFT = 14;
  localparam int IDX_BITS   = 6;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_STEPS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_FRAC  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_FRAC = 2'd2;

  localparam logic [NS_BITS-1:0]          NUM_STEPS_RESET   = 7'd8;
  localparam logic signed [FRAC_BITS-1:0] FIRST_FRAC_RESET  = 16'sd4096;
  localparam logic signed [FRAC_BITS-1:0] SECOND_FRAC_RESET = 16'sd12288;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

// File: sv/btg_sequencer.sv
// Point sequencer: latches a vertex pair and issues one curve parameter per cycle
// while advance is high. The parameter step comes from a constant reciprocal table. Depends on btg_pkg.
module btg_sequencer #(
  parameter int MAX_STEPS   = btg_pkg::DEF_MAX_STEPS,
  parameter int COORD_BITS  = btg_pkg::DEF_COORD_BITS,
  parameter int T_FRAC_BITS = btg_pkg::DEF_T_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [btg_pkg::NS_BITS-1:0]     num_steps,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    start_x,
  input  logic signed [COORD_BITS-1:0]    start_y,
  input  logic signed [COORD_BITS-1:0]    target_x,
  input  logic signed [COORD_BITS-1:0]    target_y,
  output btg_pkg::ctl_t                   s0_ctl,
  output logic [$clog2(MAX_STEPS)-1:0]    s0_j,
  output logic [T_FRAC_BITS:0]            s0_t,
  output logic signed [COORD_BITS-1:0]    s0_ax,
  output logic signed [COORD_BITS-1:0]    s0_ay,
  output logic signed [COORD_BITS-1:0]    s0_bx,
  output logic signed [COORD_BITS-1:0]    s0_by
);
  import btg_pkg::*;

  localparam int JW = $clog2(MAX_STEPS);
  localparam int DW = JW + 1;
  localparam int TW = T_FRAC_BITS + 1;
  localparam longint STEP_NUM = longint'(1) << (T_FRAC_BITS + 1);

  logic [TW-1:0] q_tab [MAX_STEPS];
  logic [DW-1:0] r_tab [MAX_STEPS];

  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_tab
    if (g == 0) begin : g_unused
      assign q_tab[g] = '0;
      assign r_tab[g] = '0;
    end else begin : g_entry
      localparam longint Q = STEP_NUM / (2 * g);
      localparam longint R = STEP_NUM % (2 * g);
      assign q_tab[g] = TW'(Q);
      assign r_tab[g] = DW'(R);
    end
  end

  logic          active;
  logic [JW-1:0] j;
  logic [JW-1:0] last_j;
  logic [TW-1:0] t_q;
  logic [DW-1:0] t_r;
  logic [TW-1:0] q0;
  logic [DW-1:0] r0;
  logic [DW-1:0] den;
  logic [TW-1:0] t_q_next;
  logic [DW-1:0] t_r_next;
  logic [DW:0]   r_sum;
  logic [JW-1:0] m_sel;
  logic          at_last;
  logic          accept;

  always_comb begin
    if (int'(num_steps) < 2) begin
      m_sel = JW'(1);
    end else if (int'(num_steps) > MAX_STEPS) begin
      m_sel = JW'(MAX_STEPS - 1);
    end else begin
      m_sel = JW'(int'(num_steps) - 1);
    end
  end

  always_comb begin
    r_sum = {1'b0, t_r} + {1'b0, r0};
    if (r_sum >= {1'b0, den}) begin
      t_r_next = DW'(r_sum - {1'b0, den});
      t_q_next = t_q + q0 + TW'(1);
    end else begin
      t_r_next = r_sum[DW-1:0];
      t_q_next = t_q + q0;
    end
  end

  assign at_last  = (j == last_j);
  assign in_stall = active && !(advance && at_last);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      active <= 1'b1;
      j      <= '0;
      last_j <= m_sel;
      t_q    <= '0;
      t_r    <= {1'b0, m_sel};
      q0     <= q_tab[m_sel];
      r0     <= r_tab[m_sel];
      den    <= {m_sel, 1'b0};
      s0_ax  <= start_x;
      s0_ay  <= start_y;
      s0_bx  <= target_x;
      s0_by  <= target_y;
    end else if (advance && active) begin
      if (at_last) begin
        active <= 1'b0;
      end else begin
        j   <= j + JW'(1);
        t_q <= t_q_next;
        t_r <= t_r_next;
      end
    end
  end

  assign s0_ctl.valid = active;
  assign s0_ctl.last  = at_last;
  assign s0_j         = j;
  assign s0_t         = t_q;

endmodule

// File: sv/btg_weights.sv
// Bernstein weight pipeline: squares, cubes and the factor three, one stage each.
// Carries the point's valid, last flag and index alongside. Depends on btg_pkg.
module btg_weights #(
  parameter int MAX_STEPS   = btg_pkg::DEF_MAX_STEPS,
  parameter int T_FRAC_BITS = btg_pkg::DEF_T_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  btg_pkg::ctl_t                s0_ctl,
  input  logic [$clog2(MAX_STEPS)-1:0] s0_j,
  input  logic [T_FRAC_BITS:0]         s0_t,
  output btg_pkg::ctl_t                s3_ctl,
  output logic [$clog2(MAX_STEPS)-1:0] s3_j,
  output logic [T_FRAC_BITS+1:0]       w0,
  output logic [T_FRAC_BITS+1:0]       w1,
  output logic [T_FRAC_BITS+1:0]       w2,
  output logic [T_FRAC_BITS+1:0]       w3
);
  import btg_pkg::*;

  localparam int JW = $clog2(MAX_STEPS);
  localparam int TW = T_FRAC_BITS + 1;
  localparam int WW = T_FRAC_BITS + 2;
  localparam logic [TW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  ctl_t          s1_ctl, s2_ctl;
  logic [JW-1:0] s1_j, s2_j;
  logic [TW-1:0] s1_t, s1_u, uu, ut, tt;
  logic [TW-1:0] b0, c1, c2, b3;
  logic [TW-1:0] u_next;
  logic [2*TW-1:0] p_uu, p_ut, p_tt, p_b0, p_c1, p_c2, p_b3;

  always_comb begin
    u_next = ONE - s0_t;
    p_uu   = u_next * u_next;
    p_ut   = u_next * s0_t;
    p_tt   = s0_t * s0_t;
    p_b0   = uu * s1_u;
    p_c1   = uu * s1_t;
    p_c2   = ut * s1_t;
    p_b3   = tt * s1_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
      s3_ctl <= '0;
    end else if (advance) begin
      s1_ctl <= s0_ctl;
      s2_ctl <= s1_ctl;
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_j <= s0_j;
      s1_t <= s0_t;
      s1_u <= u_next;
      uu   <= p_uu[T_FRAC_BITS +: TW];
      ut   <= p_ut[T_FRAC_BITS +: TW];
      tt   <= p_tt[T_FRAC_BITS +: TW];
      s2_j <= s1_j;
      b0   <= p_b0[T_FRAC_BITS +: TW];
      c1   <= p_c1[T_FRAC_BITS +: TW];
      c2   <= p_c2[T_FRAC_BITS +: TW];
      b3   <= p_b3[T_FRAC_BITS +: TW];
      s3_j <= s2_j;
      w0   <= WW'(b0);
      w1   <= {c1, 1'b0} + WW'(c1);
      w2   <= {c2, 1'b0} + WW'(c2);
      w3   <= WW'(b3);
    end
  end

endmodule

// File: sv/btg_ctrl.sv
// Control point pipeline: places the two inner control points along the line
// from start to target and aligns all four points with the weights. Depends on btg_pkg.
module btg_ctrl #(
  parameter int COORD_BITS = btg_pkg::DEF_COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 advance,
  input  logic signed [btg_pkg::FRAC_BITS-1:0] first_frac,
  input  logic signed [btg_pkg::FRAC_BITS-1:0] second_frac,
  input  logic signed [COORD_BITS-1:0]         s0_ax,
  input  logic signed [COORD_BITS-1:0]         s0_ay,
  input  logic signed [COORD_BITS-1:0]         s0_bx,
  input  logic signed [COORD_BITS-1:0]         s0_by,
  output logic signed [COORD_BITS+2:0]         p0x,
  output logic signed [COORD_BITS+2:0]         p1x,
  output logic signed [COORD_BITS+2:0]         p2x,
  output logic signed [COORD_BITS+2:0]         p3x,
  output logic signed [COORD_BITS+2:0]         p0y,
  output logic signed [COORD_BITS+2:0]         p1y,
  output logic signed [COORD_BITS+2:0]         p2y,
  output logic signed [COORD_BITS+2:0]         p3y
);
  import btg_pkg::*;

  localparam int CPB  = COORD_BITS + 3;
  localparam int NUMW = COORD_BITS + 17;
  localparam logic signed [NUMW-1:0] TRUNC_BIAS = NUMW'((1 <<< FRAC_SHIFT) - 1);

  logic signed [COORD_BITS:0]   dx, dy;
  logic signed [NUMW-1:0]       n1x_next, n2x_next, n1y_next, n2y_next;
  logic signed [NUMW-1:0]       n1x, n2x, n1y, n2y;
  logic signed [COORD_BITS-1:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic signed [CPB-1:0]        s2_ax, s2_ay, s2_bx, s2_by;
  logic signed [CPB-1:0]        c1x, c2x, c1y, c2y;

  function automatic logic signed [CPB-1:0] trunc_div(input logic signed [NUMW-1:0] v);
    logic signed [NUMW-1:0] biased;
    biased = v + (v[NUMW-1] ? TRUNC_BIAS : NUMW'(0));
    return CPB'(biased >>> FRAC_SHIFT);
  endfunction

  always_comb begin
    dx       = (COORD_BITS+1)'(s0_bx) - (COORD_BITS+1)'(s0_ax);
    dy       = (COORD_BITS+1)'(s0_by) - (COORD_BITS+1)'(s0_ay);
    n1x_next = (NUMW'(s0_ax) <<< FRAC_SHIFT) + NUMW'(dx) * NUMW'(first_frac);
    n2x_next = (NUMW'(s0_ax) <<< FRAC_SHIFT) + NUMW'(dx) * NUMW'(second_frac);
    n1y_next = (NUMW'(s0_ay) <<< FRAC_SHIFT) + NUMW'(dy) * NUMW'(first_frac);
    n2y_next = (NUMW'(s0_ay) <<< FRAC_SHIFT) + NUMW'(dy) * NUMW'(second_frac);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      n1x   <= n1x_next;
      n2x   <= n2x_next;
      n1y   <= n1y_next;
      n2y   <= n2y_next;
      s1_ax <= s0_ax;
      s1_ay <= s0_ay;
      s1_bx <= s0_bx;
      s1_by <= s0_by;
      c1x   <= trunc_div(n1x);
      c2x   <= trunc_div(n2x);
      c1y   <= trunc_div(n1y);
      c2y   <= trunc_div(n2y);
      s2_ax <= CPB'(s1_ax);
      s2_ay <= CPB'(s1_ay);
      s2_bx <= CPB'(s1_bx);
      s2_by <= CPB'(s1_by);
      p0x   <= s2_ax;
      p1x   <= c1x;
      p2x   <= c2x;
      p3x   <= s2_bx;
      p0y   <= s2_ay;
      p1y   <= c1y;
      p2y   <= c2y;
      p3y   <= s2_by;
    end
  end

endmodule

// File: sv/btg_combine.sv
// Weighted sum pipeline: products, pair sums, total, then rounding and saturation
// into the output register. Depends on btg_pkg.
module btg_combine #(
  parameter int MAX_STEPS   = btg_pkg::DEF_MAX_STEPS,
  parameter int COORD_BITS  = btg_pkg::DEF_COORD_BITS,
  parameter int T_FRAC_BITS = btg_pkg::DEF_T_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  btg_pkg::ctl_t                     s3_ctl,
  input  logic [$clog2(MAX_STEPS)-1:0]      s3_j,
  input  logic [T_FRAC_BITS+1:0]            w0,
  input  logic [T_FRAC_BITS+1:0]            w1,
  input  logic [T_FRAC_BITS+1:0]            w2,
  input  logic [T_FRAC_BITS+1:0]            w3,
  input  logic signed [COORD_BITS+2:0]      p0x,
  input  logic signed [COORD_BITS+2:0]      p1x,
  input  logic signed [COORD_BITS+2:0]      p2x,
  input  logic signed [COORD_BITS+2:0]      p3x,
  input  logic signed [COORD_BITS+2:0]      p0y,
  input  logic signed [COORD_BITS+2:0]      p1y,
  input  logic signed [COORD_BITS+2:0]      p2y,
  input  logic signed [COORD_BITS+2:0]      p3y,
  output logic                              out_valid,
  output logic signed [COORD_BITS-1:0]      point_x,
  output logic signed [COORD_BITS-1:0]      point_y,
  output logic [btg_pkg::IDX_BITS-1:0]      step_index,
  output logic                              last_point
);
  import btg_pkg::*;

  localparam int JW  = $clog2(MAX_STEPS);
  localparam int CPB = COORD_BITS + 3;
  localparam int WW  = T_FRAC_BITS + 2;
  localparam int PW  = WW + 1 + CPB;
  localparam int SW  = PW + 2;
  localparam int RW  = SW + 1;
  localparam logic signed [RW-1:0] HALF    = RW'(1) <<< (T_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] HALF_DN = HALF - RW'(1);
  localparam logic signed [RW-1:0] HI      = (RW'(1) <<< (COORD_BITS - 1)) - RW'(1);
  localparam logic signed [RW-1:0] LO      = -(RW'(1) <<< (COORD_BITS - 1));

  ctl_t          s4_ctl, s5_ctl, s6_ctl;
  logic [JW-1:0] s4_j, s5_j, s6_j;
  logic signed [PW-1:0]   m0x, m1x, m2x, m3x, m0y, m1y, m2y, m3y;
  logic signed [PW-1:0]   m0x_next, m1x_next, m2x_next, m3x_next;
  logic signed [PW-1:0]   m0y_next, m1y_next, m2y_next, m3y_next;
  logic signed [PW:0]     ax, bx, ay, by;
  logic signed [SW-1:0]   sx, sy;

  function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [RW-1:0] biased;
    logic signed [RW-1:0] q;
    logic signed [COORD_BITS-1:0] r;
    biased = RW'(s) + (s[SW-1] ? HALF_DN : HALF);
    q = biased >>> T_FRAC_BITS;
    if (q > HI) begin
      r = HI[COORD_BITS-1:0];
    end else if (q < LO) begin
      r = LO[COORD_BITS-1:0];
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    m0x_next = $signed({1'b0, w0}) * p0x;
    m1x_next = $signed({1'b0, w1}) * p1x;
    m2x_next = $signed({1'b0, w2}) * p2x;
    m3x_next = $signed({1'b0, w3}) * p3x;
    m0y_next = $signed({1'b0, w0}) * p0y;
    m1y_next = $signed({1'b0, w1}) * p1y;
    m2y_next = $signed({1'b0, w2}) * p2y;
    m3y_next = $signed({1'b0, w3}) * p3y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl    <= '0;
      s5_ctl    <= '0;
      s6_ctl    <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s4_ctl    <= s3_ctl;
      s5_ctl    <= s4_ctl;
      s6_ctl    <= s5_ctl;
      out_valid <= s6_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_j       <= s3_j;
      m0x        <= m0x_next;
      m1x        <= m1x_next;
      m2x        <= m2x_next;
      m3x        <= m3x_next;
      m0y        <= m0y_next;
      m1y        <= m1y_next;
      m2y        <= m2y_next;
      m3y        <= m3y_next;
      s5_j       <= s4_j;
      ax         <= (PW+1)'(m0x) + (PW+1)'(m1x);
      bx         <= (PW+1)'(m2x) + (PW+1)'(m3x);
      ay         <= (PW+1)'(m0y) + (PW+1)'(m1y);
      by         <= (PW+1)'(m2y) + (PW+1)'(m3y);
      s6_j       <= s5_j;
      sx         <= SW'(ax) + SW'(bx);
      sy         <= SW'(ay) + SW'(by);
      point_x    <= round_sat(sx);
      point_y    <= round_sat(sy);
      step_index <= IDX_BITS'(s6_j);
      last_point <= s6_ctl.last;
    end
  end

endmodule

// File: sv/bezier_trajectory_generator.sv
// Cubic Bezier trajectory generator, top level: configuration registers and
// the point pipeline. Depends on btg_pkg and the btg_* pipeline modules.
//
// Usage: each transfer on the input channel (in_valid, in_stall) carries one
// vertex pair. The block emits N points along the curve between them on the
// output channel (out_valid, out_stall), where N is num_steps limited to the
// range two to MAX_STEPS. step_index counts the points and last_point marks
// the final one. Configuration is written through cfg_valid, cfg_ready,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce; cfg_ready is always high.
// Throughput: one point per cycle unless the receiver stalls, set by the
// sequencer issuing one curve parameter per cycle; the next pair is taken
// in the cycle that issues the last point of the current one.
// Reset clears the pipeline, drops any run in progress and restores the
// register defaults (eight points, fractions 0.25 and 0.75). When the
// receiver stalls, the whole pipeline holds and in_stall rises as soon as a
// run is in progress.
module bezier_trajectory_generator #(
  parameter int MAX_STEPS   = btg_pkg::DEF_MAX_STEPS,
  parameter int COORD_BITS  = btg_pkg::DEF_COORD_BITS,
  parameter int T_FRAC_BITS = btg_pkg::DEF_T_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        target_x,
  input  logic signed [COORD_BITS-1:0]        target_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        point_x,
  output logic signed [COORD_BITS-1:0]        point_y,
  output logic [btg_pkg::IDX_BITS-1:0]        step_index,
  output logic                                last_point,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [btg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import btg_pkg::*;

  localparam int JW = $clog2(MAX_STEPS);

  logic [NS_BITS-1:0]          num_steps;
  logic signed [FRAC_BITS-1:0] first_frac;
  logic signed [FRAC_BITS-1:0] second_frac;
  logic                        advance;

  ctl_t                         s0_ctl, s3_ctl;
  logic [JW-1:0]                s0_j, s3_j;
  logic [T_FRAC_BITS:0]         s0_t;
  logic signed [COORD_BITS-1:0] s0_ax, s0_ay, s0_bx, s0_by;
  logic [T_FRAC_BITS+1:0]       w0, w1, w2, w3;
  logic signed [COORD_BITS+2:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps   <= NUM_STEPS_RESET;
      first_frac  <= FIRST_FRAC_RESET;
      second_frac <= SECOND_FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_STEPS:   num_steps   <= cfg_data[NS_BITS-1:0];
        CFG_FIRST_FRAC:  first_frac  <= cfg_data;
        CFG_SECOND_FRAC: second_frac <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  btg_sequencer #(
    .MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)
  ) u_seq (
    .clk(clk), .rst(rst), .advance(advance), .num_steps(num_steps),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .target_x(target_x), .target_y(target_y),
    .s0_ctl(s0_ctl), .s0_j(s0_j), .s0_t(s0_t),
    .s0_ax(s0_ax), .s0_ay(s0_ay), .s0_bx(s0_bx), .s0_by(s0_by)
  );

  btg_weights #(
    .MAX_STEPS(MAX_STEPS), .T_FRAC_BITS(T_FRAC_BITS)
  ) u_weights (
    .clk(clk), .rst(rst), .advance(advance),
    .s0_ctl(s0_ctl), .s0_j(s0_j), .s0_t(s0_t),
    .s3_ctl(s3_ctl), .s3_j(s3_j), .w0(w0), .w1(w1), .w2(w2), .w3(w3)
  );

  btg_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk(clk), .advance(advance), .first_frac(first_frac), .second_frac(second_frac),
    .s0_ax(s0_ax), .s0_ay(s0_ay), .s0_bx(s0_bx), .s0_by(s0_by),
    .p0x(p0x), .p1x(p1x), .p2x(p2x), .p3x(p3x),
    .p0y(p0y), .p1y(p1y), .p2y(p2y), .p3y(p3y)
  );

  btg_combine #(
    .MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)
  ) u_combine (
    .clk(clk), .rst(rst), .advance(advance),
    .s3_ctl(s3_ctl), .s3_j(s3_j), .w0(w0), .w1(w1), .w2(w2), .w3(w3),
    .p0x(p0x), .p1x(p1x), .p2x(p2x), .p3x(p3x),
    .p0y(p0y), .p1y(p1y), .p2y(p2y), .p3y(p3y),
    .out_valid(out_valid), .point_x(point_x), .point_y(point_y),
    .step_index(step_index), .last_point(last_point)
  );

endmodule

// File: sv/btg_checker.sv
// Port-level checker for the cubic Bezier trajectory generator, with its bind.
// Depends on btg_pkg and bezier_trajectory_generator_defines.svh.
`include "bezier_trajectory_generator_defines.svh"

module btg_checker #(
  parameter int COORD_BITS = btg_pkg::DEF_COORD_BITS
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [COORD_BITS-1:0]   point_x,
  input logic signed [COORD_BITS-1:0]   point_y,
  input logic [btg_pkg::IDX_BITS-1:0]   step_index,
  input logic                           last_point
);
  import btg_pkg::*;

  // Reset leaves the pipeline empty and the input open.
  `BTG_ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid && !in_stall, "not empty after reset")

  // A stalled result holds.
  `BTG_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(point_x) && $stable(point_y) && $stable(step_index) && $stable(last_point), "stalled result changed")

  // Points of one run follow each other without gaps.
  `BTG_ASSERT_NEXT(a_run_step, out_valid && !out_stall && !last_point, out_valid && (step_index == $past(step_index) + 6'd1), "run point missing or out of order")

  // After the last point of a run, the next point opens a new run.
  `BTG_ASSERT_NEXT(a_run_restart, out_valid && !out_stall && last_point, !out_valid || (step_index == 6'd0), "new run does not start at index zero")

endmodule

bind bezier_trajectory_generator btg_checker #(.COORD_BITS(COORD_BITS)) u_btg_checker (.*);
